// File: rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 stream hash: round constants,
// initial chaining words, controller states and controller/datapath buses.
// ---------------------------------------------------------------------------
package sha1_pkg;

   localparam int unsigned HASH_WORDS = 5;
   localparam int unsigned SCHED_WORDS = 16;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] ROUND_B1 = 7'd20;
   localparam logic [6:0] ROUND_B2 = 7'd40;
   localparam logic [6:0] ROUND_B3 = 7'd60;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] H_INIT [HASH_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] CNT_LAST = 6'd63;
   localparam logic [5:0] CNT_LEN = 6'd56;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;
   localparam logic [2:0] WORD_LAST = 3'd4;

   typedef enum logic [1:0] {
      SRC_MSG  = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PAD_ONE  = 8'b0000_0010,
      ST_PAD_ZERO = 8'b0000_0100,
      ST_PAD_LEN  = 8'b0000_1000,
      ST_CLOAD    = 8'b0001_0000,
      ST_ROUND    = 8'b0010_0000,
      ST_FOLD     = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic         shift_en;
      byte_src_type src;
      logic         len_add;
      logic         load_work;
      logic         round_en;
      logic         fold;
      logic         clear_msg;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic cnt_len;
      logic round_last;
   } dp_status_type;

endpackage

// File: rtl/sha1_stream_hash.sv
// Throughput: one request per cycle while a block fills; each full 64-byte
// block then runs load, 80 rounds and fold in the single round unit, and no
// request is taken meanwhile. An end request adds padding bytes up to the
// end of the block, a pause with no shift where the zero fill meets the
// length field, one or two padding blocks compressed the same way, then five
// digest words at one per accepted cycle. Reset: synchronous; chaining words
// return to the SHA-1 initial values.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 hash over a byte stream: byte requests in, five digest words out.
// ---------------------------------------------------------------------------
module sha1_stream_hash (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   // digest channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha1_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    word_idx;

   // Sequencer: take bytes, drive padding, run rounds, hand out digest words.
   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_byte_valid (req_tuser),
      .req_tlast      (req_tlast),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .word_idx       (word_idx),
      .cmd            (cmd),
      .status         (status)
   );

   // Block shift line, counters, round logic and chaining words.
   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_byte    (req_tdata),
      .word_idx    (word_idx),
      .status      (status),
      .digest_word (rsp_tdata)
   );

   // Hold the word index on the sideband; flag the final word.
   assign rsp_tuser = word_idx;
   assign rsp_tlast = (word_idx == WORD_LAST);

endmodule

// File: rtl/sha1_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_datapath
// Message block shift line, byte and bit counters, one compression round
// per cycle and the chaining words.
// ---------------------------------------------------------------------------
module sha1_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  sha1_pkg::dp_cmd_type    cmd,
   input  logic [7:0]              msg_byte,
   input  logic [2:0]              word_idx,
   output sha1_pkg::dp_status_type status,
   output logic [31:0]             digest_word
);
   import sha1_pkg::*;

   logic [31:0] hash_ff [HASH_WORDS];
   logic [31:0] hash_in [HASH_WORDS];
   logic [31:0] sched_ff [SCHED_WORDS];
   logic [31:0] sched_in [SCHED_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  round_ff, round_in;

   logic [7:0]  fill_byte;
   logic [63:0] len_shift;
   logic [31:0] w_mix, w_new, f_val, k_val, t_sum;

   // byte to shift into the block
   always_comb begin
      len_shift = len_ff << {cnt_ff[2:0], 3'b000};
      case (cmd.src)
         SRC_MSG:  fill_byte = msg_byte;
         SRC_PAD:  fill_byte = PAD_BYTE;
         SRC_ZERO: fill_byte = 8'h00;
         SRC_LEN:  fill_byte = len_shift[63:56];
         default:  fill_byte = 8'h00;
      endcase
   end

   // one SHA-1 round; the shift line always holds W[t] .. W[t+15]
   always_comb begin
      w_mix = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_new = {w_mix[30:0], w_mix[31]};
      if (round_ff < ROUND_B1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < ROUND_B2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < ROUND_B3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
      t_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + sched_ff[0] + k_val;
   end

   always_comb begin
      for (int i = 0; i < SCHED_WORDS; i++) begin
         sched_in[i] = sched_ff[i];
      end
      if (cmd.shift_en) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_in[SCHED_WORDS-1] = {sched_ff[SCHED_WORDS-1][23:0], fill_byte};
      end else if (cmd.round_en) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[SCHED_WORDS-1] = w_new;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      round_in = round_ff;
      if (cmd.load_work) begin
         a_in = hash_ff[0];
         b_in = hash_ff[1];
         c_in = hash_ff[2];
         d_in = hash_ff[3];
         e_in = hash_ff[4];
         round_in = '0;
      end else if (cmd.round_en) begin
         a_in = t_sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         round_in = status.round_last ? '0 : round_ff + 7'd1;
      end
   end

   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) begin
         hash_in[i] = hash_ff[i];
      end
      cnt_in = cnt_ff;
      len_in = len_ff;
      if (cmd.clear_msg) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_in[i] = H_INIT[i];
         end
         cnt_in = '0;
         len_in = '0;
      end else begin
         if (cmd.fold) begin
            hash_in[0] = hash_ff[0] + a_ff;
            hash_in[1] = hash_ff[1] + b_ff;
            hash_in[2] = hash_ff[2] + c_ff;
            hash_in[3] = hash_ff[3] + d_ff;
            hash_in[4] = hash_ff[4] + e_ff;
         end
         if (cmd.shift_en) begin
            cnt_in = cnt_ff + 6'd1;
         end
         if (cmd.len_add) begin
            len_in = len_ff + BITS_PER_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= H_INIT[i];
         end
         cnt_ff   <= '0;
         len_ff   <= '0;
         round_ff <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         d_ff     <= '0;
         e_ff     <= '0;
      end else begin
         hash_ff  <= hash_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         e_ff     <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
   end

   always_comb begin
      status.cnt_last   = (cnt_ff == CNT_LAST);
      status.cnt_len    = (cnt_ff == CNT_LEN);
      status.round_last = (round_ff == ROUND_LAST);
      case (word_idx)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         3'd4:    digest_word = hash_ff[4];
         default: digest_word = hash_ff[0];
      endcase
   end

endmodule

// File: rtl/sha1_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ---------------------------------------------------------------------------
module sha1_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_byte_valid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2:0]              word_idx,
   output sha1_pkg::dp_cmd_type    cmd,
   input  sha1_pkg::dp_status_type status
);
   import sha1_pkg::*;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [2:0]  idx_ff, idx_in;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.src    = SRC_MSG;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.shift_en = req_byte_valid;
               cmd.len_add  = req_byte_valid;
               if (req_byte_valid && status.cnt_last) begin
                  if (req_tlast) begin
                     ret_in = ST_PAD_ONE;
                  end else begin
                     ret_in = ST_IDLE;
                  end
                  state_in = ST_CLOAD;
               end else if (req_tlast) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_PAD_ONE: begin
            cmd.shift_en = 1'b1;
            cmd.src      = SRC_PAD;
            if (status.cnt_last) begin
               ret_in   = ST_PAD_ZERO;
               state_in = ST_CLOAD;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.cnt_len) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.src      = SRC_ZERO;
               if (status.cnt_last) begin
                  ret_in   = ST_PAD_ZERO;
                  state_in = ST_CLOAD;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.src      = SRC_LEN;
            if (status.cnt_last) begin
               ret_in   = ST_OUT;
               state_in = ST_CLOAD;
            end
         end
         ST_CLOAD: begin
            cmd.load_work = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (idx_ff == WORD_LAST) begin
                  idx_in        = '0;
                  cmd.clear_msg = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

   assign word_idx = idx_ff;

endmodule
